@@ design/bounded_priority_queue_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bounded priority queue unit
// Shared concurrent assertion forms, all clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define BOUNDED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Condition that must hold at every edge outside reset
`define BPQ_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Consequent checked in the same cycle as the antecedent
`define BPQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent
`define BPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/bpq_pkg.sv @@
// ----------------------------------------------------------------------------
// bpq_pkg
// Types and constants shared by the priority queue cell chain and top level.
// ----------------------------------------------------------------------------
package bpq_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int OCC_W    = 5;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // what every cell does in a given cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      logic signed [31:0] data;
      logic [7:0]         rank;
   } entry_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   new_entry;
   } cell_ctrl_type;

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] in_data;
      logic [7:0]         in_priority;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_data;
      logic [7:0]         out_priority;
      status_type         status;
      logic [OCC_W-1:0]   occupancy;
      logic               now_empty;
      logic               now_full;
   } rsp_type;

endpackage

@@ design/bpq_cell.sv @@
// ----------------------------------------------------------------------------
// bpq_cell
// One slot of the sorted chain: keeps, takes the new entry, or takes a neighbour.
// ----------------------------------------------------------------------------
module bpq_cell import bpq_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occupied,
   input  entry_type     left_entry,
   input  logic          left_stay,
   input  entry_type     right_entry,
   output entry_type     entry,
   output logic          stay
);

   entry_type entry_ff;
   entry_type entry_in;

   // an occupied slot ranked at or above the newcomer keeps its place (ties FIFO)
   assign stay  = occupied && (entry_ff.rank >= ctrl.new_entry.rank);
   assign entry = entry_ff;

   // next slot contents
   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (stay) begin
               entry_in = entry_ff;
            end else if (left_stay) begin
               entry_in = ctrl.new_entry;
            end else begin
               entry_in = left_entry;
            end
         end
         CELL_SHIFT: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ design/bounded_priority_queue_unit.sv @@
// The result of a transaction is registered and presented in the cycle after acceptance.
// Throughput: one transaction per cycle unless a pending result is stalled; each cell
// compares only with the incoming rank and its left neighbour, so the sorted chain updates in one step.
// Reset clears the fill count and the result valid flag; cell contents stay
// undefined and are never read before being written.
// ----------------------------------------------------------------------------
// bounded_priority_queue_unit
// Max-first, tie-FIFO priority queue built as a sorted shift chain of cells.
// ----------------------------------------------------------------------------
module bounded_priority_queue_unit import bpq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

`include "bounded_priority_queue_unit_assert.svh"

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   cell_ctrl_type    ctrl;
   entry_type        cell_entry [CAPACITY];
   logic             cell_stay  [CAPACITY];
   logic             req_accept;
   logic             is_full;
   logic             is_empty;

   // handshake: the result register frees when its transaction is taken
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign is_full    = (count_ff == CNT_W'(CAPACITY));
   assign is_empty   = (count_ff == '0);

   // command decode, next count and result
   always_comb begin
      ctrl.op                  = CELL_HOLD;
      ctrl.new_entry.data      = req_payload.in_data;
      ctrl.new_entry.rank      = req_payload.in_priority;
      count_in                 = count_ff;
      rsp_in                   = rsp_ff;
      rsp_valid_in             = rsp_valid_ff && rsp_stall;
      if (req_accept) begin
         rsp_valid_in        = 1'b1;
         rsp_in.out_data     = '0;
         rsp_in.out_priority = '0;
         rsp_in.status       = STATUS_OK;
         if (req_payload.cmd == CMD_ENQUEUE) begin
            if (is_full) begin
               rsp_in.status = STATUS_FULL;
            end else begin
               ctrl.op  = CELL_INSERT;
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (is_empty) begin
               rsp_in.status = STATUS_EMPTY;
            end else begin
               ctrl.op             = CELL_SHIFT;
               count_in            = count_ff - 1'b1;
               rsp_in.out_data     = cell_entry[0].data;
               rsp_in.out_priority = cell_entry[0].rank;
            end
         end
         rsp_in.occupancy = OCC_W'(count_in);
         rsp_in.now_empty = (count_in == '0);
         rsp_in.now_full  = (count_in == CNT_W'(CAPACITY));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // the cell chain, head at index zero
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      occupied;
      entry_type left_entry;
      logic      left_stay;
      entry_type right_entry;

      assign occupied = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_entry = ctrl.new_entry;
         assign left_stay  = 1'b1;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_stay  = cell_stay[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      bpq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occupied),
         .left_entry  (left_entry),
         .left_stay   (left_stay),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .stay        (cell_stay[i])
      );
   end

   // assertions
   `BPQ_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(CAPACITY), "fill count above capacity")
   `BPQ_ASSERT_NEXT(a_enq_count, req_accept && req_payload.cmd == CMD_ENQUEUE && !is_full, count_ff == CNT_W'($past(count_ff) + 1'b1), "enqueue did not grow the count")
   `BPQ_ASSERT_NEXT(a_deq_head, req_accept && req_payload.cmd == CMD_DEQUEUE && !is_empty, rsp_payload.out_priority == $past(cell_entry[0].rank), "dequeue did not return the head")

   for (genvar j = 0; j < CAPACITY - 1; j++) begin : g_order_chk
      `BPQ_ASSERT_SAME(a_sorted, CNT_W'(j + 1) < count_ff, cell_entry[j].rank >= cell_entry[j+1].rank, "cell chain out of order")
   end

endmodule
